@@ design/fvta_pkg.sv @@
// ----------------------------------------------------------------------------
// fvta_pkg
// Shared types and constants of the flagged visibility time averager: item
// layouts of the sample and result channels, command and status codes, and
// configuration register map.
// ----------------------------------------------------------------------------
package fvta_pkg;

  localparam int SUM_W      = 32;
  localparam int AVG_W      = 16;
  localparam int CNT_OUT_W  = 16;
  localparam int TS_W       = 32;
  localparam int DATA_W     = 32;
  localparam int APB_ADDR_W = 2;

  typedef logic [1:0] command_t;
  typedef logic [1:0] status_t;

  localparam command_t CMD_ACCUMULATE = 2'd0;
  localparam command_t CMD_READOUT    = 2'd1;
  localparam command_t CMD_START      = 2'd2;

  localparam status_t STATUS_DONE        = 2'd0;
  localparam status_t STATUS_LATE        = 2'd1;
  localparam status_t STATUS_BAD_ANTENNA = 2'd2;

  localparam logic [APB_ADDR_W-1:0] REG_INTERVAL_ADDR = '0;
  localparam logic [DATA_W-1:0]     INTERVAL_RESET    = 32'd1000;

  localparam logic [SUM_W-1:0]     SUM_MAX     = 32'h7FFF_FFFF;
  localparam logic [SUM_W-1:0]     SUM_MIN     = 32'h8000_0000;
  localparam logic [AVG_W-1:0]     AVG_MAX     = 16'h7FFF;
  localparam logic [AVG_W-1:0]     AVG_MIN     = 16'h8000;
  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 16'hFFFF;

  typedef struct packed {
    command_t           command;
    logic [3:0]         antenna_a;
    logic [3:0]         antenna_b;
    logic [5:0]         channel_index;
    logic [1:0]         correlation_index;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               sample_flag;
    logic               row_flag;
    logic [TS_W-1:0]    timestamp;
  } sample_t;

  typedef struct packed {
    status_t                status;
    logic signed [AVG_W-1:0] average_re;
    logic signed [AVG_W-1:0] average_im;
    logic                   average_flag;
    logic [CNT_OUT_W-1:0]   average_count;
  } result_t;

endpackage

@@ design/fvta_ifs.sv @@
// ----------------------------------------------------------------------------
// fvta_ifs
// Valid/ready channels of the averager: sample items in, result items out.
// ----------------------------------------------------------------------------
interface fvta_sample_if;
  import fvta_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fvta_result_if;
  import fvta_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/fvta_ram.sv @@
// ----------------------------------------------------------------------------
// fvta_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fvta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/flagged_visibility_time_averager_top.sv @@
// ----------------------------------------------------------------------------
// flagged_visibility_time_averager_top
// Time averager of complex visibility samples with flag handling. One cell
// per baseline, channel and correlation lives in two RAMs (sums, flag+count);
// each decoded accumulate or readout reads its cell, then may write it back.
// ----------------------------------------------------------------------------
//  channel   | kind          | payload
//  ----------+---------------+-------------------------------------------
//  samples   | valid/ready   | fvta_pkg::sample_t (command, cell, sample)
//  results   | valid/ready   | fvta_pkg::result_t (status, averages)
//  apb       | psel/penable  | averaging_interval at byte address 0
//
//  One item at a time. Start, unused and refused commands go from decode
//  straight to emit; accumulate does decode, RAM read, write back, emit;
//  readout does the same, and for a nonempty cell the restoring divider
//  retires one quotient bit a cycle over 32 bits before a finishing step.
//  After rst a clearing pass writes every one of the NUM_CELLS cells
//  (34816 by default); no item is taken until it ends.
//  A result waits in the output register; the next item is taken meanwhile
//  but its result waits for that register to drain.
// ----------------------------------------------------------------------------
module flagged_visibility_time_averager_top #(
  parameter int NUM_ANTENNAS     = 16,
  parameter int NUM_CHANNELS     = 64,
  parameter int NUM_CORRELATIONS = 4,
  parameter int COUNT_BITS       = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fvta_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fvta_pkg::DATA_W-1:0]     pwdata,
  output logic [fvta_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  fvta_sample_if.sink                     samples,
  fvta_result_if.source                   results
);
  import fvta_pkg::*;

  localparam int NUM_BASELINES = (NUM_ANTENNAS * (NUM_ANTENNAS + 1)) / 2;
  localparam int NUM_CELLS     = NUM_BASELINES * NUM_CHANNELS * NUM_CORRELATIONS;
  localparam int CELL_AW       = $clog2(NUM_CELLS);
  localparam int FC_W          = COUNT_BITS + 1;
  localparam int DIV_CW        = $clog2(SUM_W);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_MODIFY = 8'b0001_0000,
    S_DIVIDE = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  function automatic logic [AVG_W-1:0] sat_avg(input logic neg, input logic [SUM_W-1:0] q);
    logic big;
    big = (q[SUM_W-1:AVG_W-1] != '0);
    if (neg) begin
      return big ? AVG_MIN : (~q[AVG_W-1:0] + 1'b1);
    end
    return big ? AVG_MAX : q[AVG_W-1:0];
  endfunction

  function automatic logic [CNT_OUT_W-1:0] count_report(input logic [COUNT_BITS-1:0] c);
    logic [31:0] cw;
    cw = 32'(c);
    return (cw > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : CNT_OUT_W'(cw);
  endfunction

  // control
  state_t              state;
  logic [CELL_AW-1:0]  clr_addr;
  logic                interval_empty;
  logic [TS_W-1:0]     interval_start;
  logic [DATA_W-1:0]   averaging_interval;
  logic                res_valid;
  logic [DIV_CW-1:0]   div_step;

  // datapath
  sample_t             item;
  logic [CELL_AW-1:0]  cell_addr;
  result_t             pend;
  result_t             res_data;
  logic [1:0][SUM_W-1:0]      quo;
  logic [1:0][COUNT_BITS-1:0] rem;
  logic [1:0]                 neg;
  logic [COUNT_BITS-1:0]      divisor;

  // decode
  logic [3:0]  ant_hi, ant_lo;
  logic [7:0]  hi_x, tri_num, baseline;
  logic [31:0] cell_index;
  logic        ant_bad, idx_bad, late, dec_go;
  logic [SUM_W:0] interval_end;
  status_t     dec_status;

  // modify
  logic [2*SUM_W-1:0]    rd_sums, wr_sums;
  logic [FC_W-1:0]       rd_fc, wr_fc;
  logic                  ram_we;
  logic [CELL_AW-1:0]    ram_waddr;
  logic                  old_flag, in_flag, readout;
  logic [COUNT_BITS-1:0] old_count;
  logic [SUM_W-1:0]      old_re, old_im, smp_re, smp_im, sat_re, sat_im;
  logic [SUM_W:0]        add_re, add_im;

  // divider
  logic [1:0][COUNT_BITS:0]   trial;
  logic [1:0]                 fits;
  logic [1:0][COUNT_BITS-1:0] rem_next;
  logic [1:0][SUM_W-1:0]      quo_next;

  logic emit_load;

  assign pready  = 1'b1;
  assign prdata  = (paddr == REG_INTERVAL_ADDR) ? averaging_interval : '0;
  assign samples.ready = (state == S_IDLE);
  assign results.valid = res_valid;
  assign results.data  = res_data;
  assign emit_load = (state == S_EMIT) && (!res_valid || results.ready);

  always_comb begin
    ant_hi = (item.antenna_a > item.antenna_b) ? item.antenna_a : item.antenna_b;
    ant_lo = (item.antenna_a > item.antenna_b) ? item.antenna_b : item.antenna_a;
    hi_x = 8'(ant_hi);
    tri_num = hi_x * (hi_x + 8'd1);
    baseline = 8'(tri_num[7:1]) + 8'(ant_lo);
    cell_index = (32'(baseline) * 32'(NUM_CHANNELS) + 32'(item.channel_index))
                 * 32'(NUM_CORRELATIONS) + 32'(item.correlation_index);
    ant_bad = (32'(item.antenna_a) >= 32'(NUM_ANTENNAS)) ||
              (32'(item.antenna_b) >= 32'(NUM_ANTENNAS));
    idx_bad = (32'(item.channel_index) >= 32'(NUM_CHANNELS)) ||
              (32'(item.correlation_index) >= 32'(NUM_CORRELATIONS));
    interval_end = {1'b0, interval_start} + {1'b0, averaging_interval};
    late = !interval_empty && ({1'b0, item.timestamp} >= interval_end);
    dec_go = 1'b0;
    priority if (item.command != CMD_ACCUMULATE && item.command != CMD_READOUT) begin
      dec_status = STATUS_DONE;
    end else if (ant_bad) begin
      dec_status = STATUS_BAD_ANTENNA;
    end else if (idx_bad) begin
      dec_status = STATUS_DONE;
    end else if (item.command == CMD_ACCUMULATE && late) begin
      dec_status = STATUS_LATE;
    end else begin
      dec_status = STATUS_DONE;
      dec_go = 1'b1;
    end
  end

  always_comb begin
    old_flag  = rd_fc[COUNT_BITS];
    old_count = rd_fc[COUNT_BITS-1:0];
    old_re    = rd_sums[2*SUM_W-1:SUM_W];
    old_im    = rd_sums[SUM_W-1:0];
    in_flag   = item.sample_flag | item.row_flag;
    readout   = (item.command == CMD_READOUT);
    smp_re    = {{(SUM_W-16){item.sample_re[15]}}, item.sample_re};
    smp_im    = {{(SUM_W-16){item.sample_im[15]}}, item.sample_im};
    add_re    = {old_re[SUM_W-1], old_re} + {smp_re[SUM_W-1], smp_re};
    add_im    = {old_im[SUM_W-1], old_im} + {smp_im[SUM_W-1], smp_im};
    sat_re    = (add_re[SUM_W] != add_re[SUM_W-1]) ?
                (add_re[SUM_W] ? SUM_MIN : SUM_MAX) : add_re[SUM_W-1:0];
    sat_im    = (add_im[SUM_W] != add_im[SUM_W-1]) ?
                (add_im[SUM_W] ? SUM_MIN : SUM_MAX) : add_im[SUM_W-1:0];

    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    wr_sums   = '0;
    wr_fc     = {1'b1, COUNT_BITS'(0)};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_MODIFY) begin
      if (readout) begin
        ram_we = 1'b1;
      end else begin
        priority if (old_flag && !in_flag) begin
          // first good sample restarts a flagged cell
          ram_we  = 1'b1;
          wr_sums = {smp_re, smp_im};
          wr_fc   = {1'b0, COUNT_BITS'(1)};
        end else if (!old_flag && in_flag) begin
          ram_we = 1'b0;
        end else if (old_count == COUNT_MAX) begin
          ram_we = 1'b0;
        end else begin
          ram_we  = 1'b1;
          wr_sums = {sat_re, sat_im};
          wr_fc   = {old_flag, old_count + 1'b1};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]    = {rem[l], quo[l][SUM_W-1]};
      fits[l]     = (trial[l] >= {1'b0, divisor});
      rem_next[l] = fits[l] ? COUNT_BITS'(trial[l] - {1'b0, divisor})
                            : trial[l][COUNT_BITS-1:0];
      quo_next[l] = {quo[l][SUM_W-2:0], fits[l]};
    end
  end

  fvta_ram #(.WIDTH(2 * SUM_W), .DEPTH(NUM_CELLS)) u_sums_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_sums),
    .re    (state == S_READ),
    .raddr (cell_addr),
    .rdata (rd_sums)
  );

  fvta_ram #(.WIDTH(FC_W), .DEPTH(NUM_CELLS)) u_flag_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_fc),
    .re    (state == S_READ),
    .raddr (cell_addr),
    .rdata (rd_fc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      clr_addr           <= '0;
      interval_empty     <= 1'b1;
      interval_start     <= '0;
      averaging_interval <= INTERVAL_RESET;
      res_valid          <= 1'b0;
      div_step           <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_INTERVAL_ADDR) begin
        averaging_interval <= pwdata;
      end
      if (emit_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == CELL_AW'(NUM_CELLS - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (samples.valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (item.command == CMD_START) begin
            interval_empty <= 1'b1;
          end
          if (dec_go) begin
            // capture start time on the first accumulate of an interval
            if (item.command == CMD_ACCUMULATE && interval_empty) begin
              interval_start <= item.timestamp;
              interval_empty <= 1'b0;
            end
            state <= S_READ;
          end else begin
            state <= S_EMIT;
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          div_step <= '0;
          if (readout && old_count != '0) begin
            state <= S_DIVIDE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DIVIDE: begin
          div_step <= div_step + 1'b1;
          if (div_step == DIV_CW'(SUM_W - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      item <= samples.data;
    end
    if (emit_load) begin
      res_data <= pend;
    end
    if (state == S_DECODE) begin
      cell_addr <= cell_index[CELL_AW-1:0];
      pend      <= '{status: dec_status, average_re: '0, average_im: '0,
                     average_flag: 1'b0, average_count: '0};
    end
    if (state == S_MODIFY && readout) begin
      pend.average_flag  <= old_flag;
      pend.average_count <= count_report(old_count);
      neg[0]  <= old_re[SUM_W-1];
      neg[1]  <= old_im[SUM_W-1];
      quo[0]  <= old_re[SUM_W-1] ? (~old_re + 1'b1) : old_re;
      quo[1]  <= old_im[SUM_W-1] ? (~old_im + 1'b1) : old_im;
      rem     <= '0;
      divisor <= old_count;
    end
    if (state == S_DIVIDE) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (state == S_FINISH) begin
      pend.average_re <= sat_avg(neg[0], quo[0]);
      pend.average_im <= sat_avg(neg[1], quo[1]);
    end
  end

endmodule

@@ design/fvta_checker.sv @@
// ----------------------------------------------------------------------------
// fvta_checker
// Port-level checks on the result channel of the averager, bound to the top.
// ----------------------------------------------------------------------------
module fvta_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input fvta_pkg::result_t res_data
);
  import fvta_pkg::*;

  // hold a stalled item
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result changed while stalled");

  // a refused item (status other than done) carries no averages, flag or count
  a_fixed_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != STATUS_DONE |->
      res_data.average_re == '0 && res_data.average_im == '0 &&
      !res_data.average_flag && res_data.average_count == '0)
    else $error("refused item carries readout fields");

  a_empty_cell: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.average_count == '0 |->
      res_data.average_re == '0 && res_data.average_im == '0)
    else $error("nonzero average with zero count");

endmodule

bind flagged_visibility_time_averager_top fvta_checker u_fvta_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_data  (results.data)
);
